FILE: design/csct_pkg.sv
package csct_pkg;

  localparam logic [31:0] UNKNOWN_KEY = 32'hFFFF_FFFF;
  localparam logic [32:0] IMAGE_SKIP  = 33'h0_0000_1000;

  // Input opcodes.
  localparam logic OP_DISPATCH = 1'b0;
  localparam logic OP_REPORT   = 1'b1;

  // Row kinds.
  localparam logic [1:0] ROW_ACK     = 2'd0;
  localparam logic [1:0] ROW_SUMMARY = 2'd1;
  localparam logic [1:0] ROW_ENTRY   = 2'd2;

  // Call forms.
  localparam logic [2:0] FORM_NONE  = 3'd0;
  localparam logic [2:0] FORM_E8    = 3'd1;
  localparam logic [2:0] FORM_FF15  = 3'd2;
  localparam logic [2:0] FORM_FFD0  = 3'd3;
  localparam logic [2:0] FORM_FF10  = 3'd4;
  localparam logic [2:0] FORM_FF50  = 3'd5;
  localparam logic [2:0] FORM_FF90  = 3'd6;
  localparam logic [2:0] FORM_FF14  = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] REG_CENSUS_ENABLE = 2'd0;
  localparam logic [1:0] REG_IMAGE_LOW     = 2'd1;
  localparam logic [1:0] REG_IMAGE_HIGH    = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [31:0] caller_return;
    logic        is_view_rotation;
    logic        bytes_readable;
    logic [7:0]  byte_back_1;
    logic [7:0]  byte_back_2;
    logic [7:0]  byte_back_3;
    logic [7:0]  byte_back_4;
    logic [7:0]  byte_back_5;
    logic [7:0]  byte_back_6;
    logic [7:0]  byte_back_7;
  } req_t;

  typedef struct packed {
    logic [1:0]  row_kind;
    logic [2:0]  call_form;
    logic [31:0] entry_key;
    logic [31:0] entry_count;
    logic [31:0] entry_delta;
    logic [31:0] dispatch_total;
    logic [31:0] unverified_total;
    logic        dropped;
    logic        last;
  } row_t;

  // The first matching form wins, in the order of the codes above.
  function automatic logic [2:0] classify(input req_t r);
    logic [2:0] form;
    form = FORM_NONE;
    if (!r.bytes_readable) begin
      form = FORM_NONE;
    end else if (r.byte_back_5 == 8'hE8) begin
      form = FORM_E8;
    end else if (r.byte_back_6 == 8'hFF && r.byte_back_5 == 8'h15) begin
      form = FORM_FF15;
    end else if (r.byte_back_2 == 8'hFF && (r.byte_back_1 & 8'hF8) == 8'hD0) begin
      form = FORM_FFD0;
    end else if (r.byte_back_2 == 8'hFF && (r.byte_back_1 & 8'hF8) == 8'h10) begin
      form = FORM_FF10;
    end else if (r.byte_back_3 == 8'hFF && (r.byte_back_2 & 8'hF8) == 8'h50) begin
      form = FORM_FF50;
    end else if (r.byte_back_6 == 8'hFF && (r.byte_back_5 & 8'hF8) == 8'h90) begin
      form = FORM_FF90;
    end else if (r.byte_back_7 == 8'hFF && r.byte_back_6 == 8'h14) begin
      form = FORM_FF14;
    end
    return form;
  endfunction

endpackage

FILE: design/csct_ram.sv
module csct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/call_site_census_table.sv
// A dispatch that is not counted goes straight to ACK, which loads its row once the output is free.
// A counted dispatch checks one key entry at a time through SCAN and CHECK; a hit, a new key
// or a dropped key then goes to ACK for its row.
// A report gives its summary row from RSUM, then one entry row per entry through RREAD and RROW,
// where each entry waits for its registered read; output stalls hold each row state.
// One item is in work at a time. Reset empties the table through the fill level at once.
module call_site_census_table #(
  parameter int SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  csct_pkg::req_t  req,
  output logic            row_valid,
  input  logic            row_ready,
  output csct_pkg::row_t  row,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] FULL = CW'(SLOTS);

  typedef enum logic [6:0] {
    IDLE  = 7'b0000001,
    SCAN  = 7'b0000010,
    CHECK = 7'b0000100,
    ACK   = 7'b0001000,
    RSUM  = 7'b0010000,
    RREAD = 7'b0100000,
    RROW  = 7'b1000000
  } state_t;

  state_t state;

  logic        census_enable;
  logic [31:0] image_low;
  logic [31:0] image_high;

  logic [CW-1:0] fill;
  logic [CW-1:0] idx;
  logic [31:0]   dispatch_cnt;
  logic [31:0]   unverified_cnt;
  logic [31:0]   key;
  logic [2:0]    form;
  logic          drop_flag;

  logic [2:0]  req_form;
  logic        in_image;
  logic        unknown;
  logic        slot_free;
  logic        row_load;
  logic        accept;

  logic          key_we, cnt_we, rep_we;
  logic [AW-1:0] key_waddr, cnt_waddr, rep_waddr;
  logic [31:0]   key_wdata, cnt_wdata, rep_wdata;
  logic [31:0]   key_rdata, cnt_rdata, rep_rdata;
  logic [AW-1:0] raddr;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == IDLE);
  assign accept    = req_valid && req_ready;
  assign slot_free = !row_valid || row_ready;
  assign row_load  = slot_free && (state == ACK || state == RSUM || state == RROW);

  assign req_form = csct_pkg::classify(req);
  // The image starts one page above its base; the sum is taken without wrap.
  assign in_image = ({1'b0, req.caller_return} >= ({1'b0, image_low} + csct_pkg::IMAGE_SKIP))
                 && (req.caller_return < image_high);
  assign unknown = !in_image || (req_form == csct_pkg::FORM_NONE);

  assign raddr = idx[AW-1:0];

  always_comb begin
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    rep_we    = 1'b0;
    key_waddr = fill[AW-1:0];
    cnt_waddr = fill[AW-1:0];
    rep_waddr = idx[AW-1:0];
    key_wdata = key;
    cnt_wdata = 32'd1;
    rep_wdata = 32'd0;
    case (state)
      SCAN: begin
        if (idx == fill && fill != FULL) begin
          key_we    = 1'b1;
          cnt_we    = 1'b1;
          rep_we    = 1'b1;
          rep_waddr = fill[AW-1:0];
        end
      end
      CHECK: begin
        if (key_rdata == key) begin
          cnt_we    = 1'b1;
          cnt_waddr = idx[AW-1:0];
          cnt_wdata = cnt_rdata + 32'd1;
        end
      end
      RROW: begin
        if (slot_free) begin
          rep_we    = 1'b1;
          rep_wdata = cnt_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  csct_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  csct_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rdata)
  );

  csct_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_reported_ram (
    .clk   (clk),
    .we    (rep_we),
    .waddr (rep_waddr),
    .wdata (rep_wdata),
    .raddr (raddr),
    .rdata (rep_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      census_enable <= 1'b0;
      image_low     <= 32'd0;
      image_high    <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csct_pkg::REG_CENSUS_ENABLE: census_enable <= cfg_data[0];
        csct_pkg::REG_IMAGE_LOW:     image_low     <= cfg_data;
        csct_pkg::REG_IMAGE_HIGH:    image_high    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      fill           <= '0;
      idx            <= '0;
      dispatch_cnt   <= 32'd0;
      unverified_cnt <= 32'd0;
      drop_flag      <= 1'b0;
      row_valid      <= 1'b0;
    end else begin
      if (row_load) begin
        row_valid <= 1'b1;
      end else if (row_valid && row_ready) begin
        row_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            idx       <= '0;
            drop_flag <= 1'b0;
            if (req.opcode == csct_pkg::OP_DISPATCH) begin
              form <= req_form;
              key  <= unknown ? csct_pkg::UNKNOWN_KEY : req.caller_return;
              if (census_enable && req.is_view_rotation) begin
                dispatch_cnt <= dispatch_cnt + 32'd1;
                if (unknown) begin
                  unverified_cnt <= unverified_cnt + 32'd1;
                end
                state <= SCAN;
              end else begin
                state <= ACK;
              end
            end else begin
              state <= RSUM;
            end
          end
        end
        SCAN: begin
          // Reaching the fill level means the key is new to the table.
          if (idx == fill) begin
            if (fill != FULL) begin
              fill <= fill + 1'b1;
            end else begin
              drop_flag <= 1'b1;
            end
            state <= ACK;
          end else begin
            state <= CHECK;
          end
        end
        CHECK: begin
          if (key_rdata == key) begin
            state <= ACK;
          end else begin
            idx   <= idx + 1'b1;
            state <= SCAN;
          end
        end
        ACK: begin
          if (slot_free) begin
            row.row_kind         <= csct_pkg::ROW_ACK;
            row.call_form        <= form;
            row.entry_key        <= 32'd0;
            row.entry_count      <= 32'd0;
            row.entry_delta      <= 32'd0;
            row.dispatch_total   <= dispatch_cnt;
            row.unverified_total <= unverified_cnt;
            row.dropped          <= drop_flag;
            row.last             <= 1'b1;
            state                <= IDLE;
          end
        end
        RSUM: begin
          if (slot_free) begin
            row.row_kind         <= csct_pkg::ROW_SUMMARY;
            row.call_form        <= csct_pkg::FORM_NONE;
            row.entry_key        <= 32'd0;
            row.entry_count      <= 32'd0;
            row.entry_delta      <= 32'd0;
            row.dispatch_total   <= dispatch_cnt;
            row.unverified_total <= unverified_cnt;
            row.dropped          <= 1'b0;
            row.last             <= (fill == '0);
            state                <= (fill == '0) ? IDLE : RREAD;
          end
        end
        RREAD: begin
          state <= RROW;
        end
        RROW: begin
          // The read address holds at idx, so the memory outputs stay put while
          // the output register is occupied.
          if (slot_free) begin
            row.row_kind         <= csct_pkg::ROW_ENTRY;
            row.call_form        <= csct_pkg::FORM_NONE;
            row.entry_key        <= key_rdata;
            row.entry_count      <= cnt_rdata;
            row.entry_delta      <= cnt_rdata - rep_rdata;
            row.dispatch_total   <= dispatch_cnt;
            row.unverified_total <= unverified_cnt;
            row.dropped          <= 1'b0;
            row.last             <= (idx + 1'b1 == fill);
            idx                  <= idx + 1'b1;
            state                <= (idx + 1'b1 == fill) ? IDLE : RREAD;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: dv/call_site_census_table_tb.sv
`timescale 1ns / 100ps

module call_site_census_table_tb;
  import csct_pkg::*;

  localparam int SLOTS = 16;
  localparam int IDLE_LIMIT = 3000;

  // Tracks the census table as the block should hold it and the rows still owed.
  class census_ledger;
    row_t        pending_rows[$];
    int          errors;
    logic [31:0] keys[SLOTS];
    logic [31:0] counts[SLOTS];
    logic [31:0] reported[SLOTS];
    int          fill;
    logic [31:0] dispatches;
    logic [31:0] unverified;
    logic        enable;
    logic [31:0] img_low;
    logic [31:0] img_high;

    function new();
      errors = 0;
      fill = 0;
      dispatches = '0;
      unverified = '0;
      enable = 1'b0;
      img_low = '0;
      img_high = '0;
    endfunction

    function void set_register(logic [1:0] index, logic [31:0] value);
      case (index)
        REG_CENSUS_ENABLE: enable = value[0];
        REG_IMAGE_LOW: img_low = value;
        REG_IMAGE_HIGH: img_high = value;
        default: ;
      endcase
    endfunction

    function logic [2:0] call_form_of(req_t r);
      if (!r.bytes_readable) return FORM_NONE;
      if (r.byte_back_5 == 8'hE8) return FORM_E8;
      if (r.byte_back_6 == 8'hFF && r.byte_back_5 == 8'h15) return FORM_FF15;
      if (r.byte_back_2 == 8'hFF && r.byte_back_1[7:3] == 5'b11010) return FORM_FFD0;
      if (r.byte_back_2 == 8'hFF && r.byte_back_1[7:3] == 5'b00010) return FORM_FF10;
      if (r.byte_back_3 == 8'hFF && r.byte_back_2[7:3] == 5'b01010) return FORM_FF50;
      if (r.byte_back_6 == 8'hFF && r.byte_back_5[7:3] == 5'b10010) return FORM_FF90;
      if (r.byte_back_7 == 8'hFF && r.byte_back_6 == 8'h14) return FORM_FF14;
      return FORM_NONE;
    endfunction

    function row_t make_row(logic [1:0] kind, logic [2:0] form, logic [31:0] key,
                            logic [31:0] cnt, logic [31:0] delta, logic drop, logic fin);
      row_t w;
      w.row_kind = kind;
      w.call_form = form;
      w.entry_key = key;
      w.entry_count = cnt;
      w.entry_delta = delta;
      w.dispatch_total = dispatches;
      w.unverified_total = unverified;
      w.dropped = drop;
      w.last = fin;
      return w;
    endfunction

    // Called for every accepted request transaction.
    function void file_request(req_t r);
      logic [2:0]  form;
      logic [31:0] key;
      logic [32:0] lower;
      logic        drop;
      logic        hit;
      if (r.opcode == OP_DISPATCH) begin
        form = call_form_of(r);
        drop = 1'b0;
        if (enable && r.is_view_rotation) begin
          dispatches = dispatches + 32'd1;
          key = r.caller_return;
          // The lower bound is formed in 33 bits so that it cannot wrap.
          lower = {1'b0, img_low} + IMAGE_SKIP;
          if (!({1'b0, r.caller_return} >= lower && r.caller_return < img_high) ||
              form == FORM_NONE) begin
            key = UNKNOWN_KEY;
            unverified = unverified + 32'd1;
          end
          hit = 1'b0;
          for (int i = 0; i < fill; i++) begin
            if (keys[i] == key) begin
              counts[i] = counts[i] + 32'd1;
              hit = 1'b1;
              break;
            end
          end
          if (!hit) begin
            if (fill < SLOTS) begin
              keys[fill] = key;
              counts[fill] = 32'd1;
              reported[fill] = '0;
              fill++;
            end else begin
              drop = 1'b1;
            end
          end
        end
        pending_rows.push_back(make_row(ROW_ACK, form, '0, '0, '0, drop, 1'b1));
      end else begin
        pending_rows.push_back(make_row(ROW_SUMMARY, FORM_NONE, '0, '0, '0, 1'b0, fill == 0));
        for (int i = 0; i < fill; i++) begin
          pending_rows.push_back(make_row(ROW_ENTRY, FORM_NONE, keys[i], counts[i],
                                          counts[i] - reported[i], 1'b0, i + 1 == fill));
          reported[i] = counts[i];
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Called for every accepted row transaction.
    function void check_row(row_t got);
      row_t want;
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = pending_rows.pop_front();
      compare_field("row_kind", want.row_kind, got.row_kind);
      compare_field("call_form", want.call_form, got.call_form);
      compare_field("entry_key", want.entry_key, got.entry_key);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("entry_delta", want.entry_delta, got.entry_delta);
      compare_field("dispatch_total", want.dispatch_total, got.dispatch_total);
      compare_field("unverified_total", want.unverified_total, got.unverified_total);
      compare_field("dropped", want.dropped, got.dropped);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        row_valid;
  logic        row_ready = 1'b0;
  row_t        row;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_CENSUS_ENABLE;
  logic [31:0] cfg_data = '0;

  census_ledger ledger = new();
  logic         steady = 1'b0;
  logic [31:0]  pool_base = 32'h0040_0000;
  int           stall_left = 0;
  int           idle_cycles = 0;

  call_site_census_table #(.SLOTS(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .row_valid(row_valid),
    .row_ready(row_ready),
    .row(row),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Row side: checks each accepted row and, unless steady, stalls at random.
  always @(posedge clk) begin : row_sink
    int unsigned pick;
    if (rst) begin
      row_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (row_valid && row_ready) ledger.check_row(row);
      if (stall_left > 0) begin
        row_ready <= 1'b0;
        stall_left--;
      end else if (steady) begin
        row_ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          row_ready <= 1'b1;
        end else begin
          row_ready <= 1'b0;
          stall_left = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (row_valid && row_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int unsigned pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic req_t make_dispatch(logic [31:0] addr, logic rot, logic readable,
                                         logic [2:0] form, logic noisy);
    req_t        r;
    logic [63:0] bytes;
    bytes = noisy ? {$urandom, $urandom} : '0;
    r.opcode = OP_DISPATCH;
    r.caller_return = addr;
    r.is_view_rotation = rot;
    r.bytes_readable = readable;
    {r.byte_back_7, r.byte_back_6, r.byte_back_5, r.byte_back_4,
     r.byte_back_3, r.byte_back_2, r.byte_back_1} = bytes[55:0];
    case (form)
      FORM_E8: r.byte_back_5 = 8'hE8;
      FORM_FF15: begin
        r.byte_back_6 = 8'hFF;
        r.byte_back_5 = 8'h15;
      end
      FORM_FFD0: begin
        r.byte_back_2 = 8'hFF;
        r.byte_back_1 = {5'b11010, bytes[58:56]};
      end
      FORM_FF10: begin
        r.byte_back_2 = 8'hFF;
        r.byte_back_1 = {5'b00010, bytes[58:56]};
      end
      FORM_FF50: begin
        r.byte_back_3 = 8'hFF;
        r.byte_back_2 = {5'b01010, bytes[58:56]};
      end
      FORM_FF90: begin
        r.byte_back_6 = 8'hFF;
        r.byte_back_5 = {5'b10010, bytes[58:56]};
      end
      FORM_FF14: begin
        r.byte_back_7 = 8'hFF;
        r.byte_back_6 = 8'h14;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly counted dispatches over a small pool of call sites, so that keys
  // repeat and the table fills; the rest are reports and raw noise.
  function automatic req_t random_request();
    req_t        r;
    logic [95:0] noise;
    logic [31:0] addr;
    int unsigned pick;
    noise = {$urandom, $urandom, $urandom};
    r = noise[$bits(req_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.opcode = OP_REPORT;
    end else if (pick >= 16) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        addr = pool_base + 32'h1000 + 32'h40 * $urandom_range(0, 19);
      end else if (pick < 85) begin
        addr = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0: addr = ledger.img_low + 32'h0FFF;
          1: addr = ledger.img_low + 32'h1000;
          2: addr = ledger.img_high - 32'd1;
          default: addr = ledger.img_high;
        endcase
      end
      r = make_dispatch(addr, $urandom_range(0, 99) < 85, $urandom_range(0, 9) != 0,
                        3'($urandom_range(0, 7)), 1'b1);
    end
    return r;
  endfunction

  // Valid is left high after acceptance so that back-to-back transactions
  // are possible; it is lowered only when a gap follows.
  task automatic send_request(input req_t r, input int gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    ledger.file_request(r);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending_rows.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    ledger.set_register(index, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic en, input logic [31:0] lo, input logic [31:0] hi,
                           input logic [31:0] base, input int items, input logic calm);
    drain();
    repeat (8) @(posedge clk);
    write_reg(REG_CENSUS_ENABLE, {31'd0, en});
    write_reg(REG_IMAGE_LOW, lo);
    write_reg(REG_IMAGE_HIGH, hi);
    steady = calm;
    pool_base = base;
    repeat (items) begin
      if ($urandom_range(0, 24) == 0) drain();
      send_request(random_request(), pick_gap());
    end
  endtask

  initial begin : stimulus
    req_t report_item;
    req_t r;
    report_item = '0;
    report_item.opcode = OP_REPORT;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_CENSUS_ENABLE, 32'd1);
    write_reg(REG_IMAGE_LOW, 32'h0040_0000);
    write_reg(REG_IMAGE_HIGH, 32'h0080_0000);

    // A report on the empty table ends with its summary row.
    send_request(report_item, pick_gap());
    send_request(make_dispatch(32'h0040_1000, 1'b1, 1'b1, FORM_E8, 1'b0), pick_gap());
    send_request(make_dispatch(32'h0040_1040, 1'b1, 1'b1, FORM_FF15, 1'b0), pick_gap());
    send_request(make_dispatch(32'h0040_1080, 1'b1, 1'b1, FORM_FFD0, 1'b0), pick_gap());
    send_request(make_dispatch(32'h0040_10C0, 1'b1, 1'b1, FORM_FF10, 1'b0), pick_gap());
    send_request(make_dispatch(32'h0040_1100, 1'b1, 1'b1, FORM_FF50, 1'b0), pick_gap());
    send_request(make_dispatch(32'h0040_1140, 1'b1, 1'b1, FORM_FF90, 1'b0), pick_gap());
    send_request(make_dispatch(32'h0040_1180, 1'b1, 1'b1, FORM_FF14, 1'b0), pick_gap());
    send_request(make_dispatch(32'h0040_1000, 1'b1, 1'b1, FORM_E8, 1'b0), pick_gap());
    // Unreadable bytes give no call form, so the key becomes the unknown one.
    send_request(make_dispatch(32'h0040_11C0, 1'b1, 1'b0, FORM_E8, 1'b0), pick_gap());
    // Image edges: one below the lower bound, the bound itself, the upper
    // bound (exclusive) and the address just under it.
    send_request(make_dispatch(32'h0040_0FFF, 1'b1, 1'b1, FORM_E8, 1'b0), pick_gap());
    send_request(make_dispatch(32'h0040_1000, 1'b1, 1'b1, FORM_FF15, 1'b0), pick_gap());
    send_request(make_dispatch(32'h0080_0000, 1'b1, 1'b1, FORM_E8, 1'b0), pick_gap());
    send_request(make_dispatch(32'h007F_FFFF, 1'b1, 1'b1, FORM_FF14, 1'b0), pick_gap());
    // Not the counted kind: form is reported but nothing is counted.
    send_request(make_dispatch(32'h0040_1200, 1'b0, 1'b1, FORM_E8, 1'b0), pick_gap());
    send_request(make_dispatch(32'h0040_1240, 1'b1, 1'b1, FORM_NONE, 1'b0), pick_gap());
    r = make_dispatch(32'h0000_0000, 1'b1, 1'b1, FORM_NONE, 1'b0);
    {r.byte_back_7, r.byte_back_6, r.byte_back_5, r.byte_back_4,
     r.byte_back_3, r.byte_back_2, r.byte_back_1} = '1;
    send_request(r, pick_gap());
    r.caller_return = 32'hFFFF_FFFF;
    send_request(r, pick_gap());
    // Bytes that match both the direct call and the register call: the
    // direct call has priority.
    r = make_dispatch(32'h0040_1280, 1'b1, 1'b1, FORM_FFD0, 1'b0);
    r.byte_back_5 = 8'hE8;
    send_request(r, pick_gap());
    send_request(report_item, pick_gap());
    send_request(report_item, pick_gap());

    run_phase(1'b1, 32'h0040_0000, 32'h0080_0000, 32'h0040_0000, 40, 1'b0);
    run_phase(1'b0, 32'h0040_0000, 32'h0080_0000, 32'h0040_0000, 20, 1'b1);
    // With the lower bound near the top, no address lies inside the image.
    run_phase(1'b1, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_F000, 30, 1'b0);
    run_phase(1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 30, 1'b0);
    run_phase(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0040_0000, 30, 1'b1);
    send_request(report_item, 0);

    drain();
    repeat (60) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending_rows.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
